FILE: hdl/sdiv_pkg.sv
// Shared types and constants for the signed divider pipeline.
`default_nettype none

package sdiv_pkg;

  localparam int unsigned Width = 32;

  typedef logic [Width-1:0] word_t;

  localparam word_t MaxPos = {1'b0, {(Width - 1){1'b1}}};
  localparam word_t MinNeg = {1'b1, {(Width - 1){1'b0}}};
  localparam word_t AllOne = {Width{1'b1}};

  typedef struct packed {
    logic num_neg;
    logic quo_neg;
    logic div_zero;
    logic ovf;
  } meta_t;

  typedef struct packed {
    word_t rem;
    word_t dq;
    word_t den;
    meta_t meta;
  } stage_t;

endpackage

`default_nettype wire

FILE: hdl/sdiv_prep.sv
// Input stage: operand magnitudes and special-case flags.
`default_nettype none

module sdiv_prep (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [sdiv_pkg::Width-1:0]   dividend_i,
  input  wire logic signed [sdiv_pkg::Width-1:0]   divisor_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output sdiv_pkg::stage_t                         out_data_o
);

  logic             valid_q;
  sdiv_pkg::stage_t data_d, data_q;
  sdiv_pkg::word_t  num_w, den_w;

  assign num_w = sdiv_pkg::word_t'(dividend_i);
  assign den_w = sdiv_pkg::word_t'(divisor_i);

  always_comb begin
    data_d.rem           = '0;
    data_d.dq            = num_w[sdiv_pkg::Width-1] ? (~num_w + sdiv_pkg::word_t'(1)) : num_w;
    data_d.den           = den_w[sdiv_pkg::Width-1] ? (~den_w + sdiv_pkg::word_t'(1)) : den_w;
    data_d.meta.num_neg  = num_w[sdiv_pkg::Width-1];
    data_d.meta.quo_neg  = num_w[sdiv_pkg::Width-1] ^ den_w[sdiv_pkg::Width-1];
    data_d.meta.div_zero = (den_w == '0);
    data_d.meta.ovf      = (num_w == sdiv_pkg::MinNeg) && (den_w == sdiv_pkg::AllOne);
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sdiv_cell.sv
// Divider cell: one restoring step, one quotient bit per beat.
`default_nettype none

module sdiv_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sdiv_pkg::stage_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sdiv_pkg::stage_t       out_data_o
);

  logic                         valid_q;
  sdiv_pkg::stage_t             data_d, data_q;
  logic [sdiv_pkg::Width:0]     part;
  logic [sdiv_pkg::Width+1:0]   diff;
  logic                         take;

  assign part = {in_data_i.rem, in_data_i.dq[sdiv_pkg::Width-1]};
  assign diff = {1'b0, part} - {2'b00, in_data_i.den};
  assign take = !diff[sdiv_pkg::Width+1];

  always_comb begin
    data_d     = in_data_i;
    data_d.rem = take ? diff[sdiv_pkg::Width-1:0] : part[sdiv_pkg::Width-1:0];
    data_d.dq  = {in_data_i.dq[sdiv_pkg::Width-2:0], take};
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sdiv_post.sv
// Output stage: sign restore, saturation and the result register.
`default_nettype none

module sdiv_post (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire sdiv_pkg::stage_t                   in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [sdiv_pkg::Width-1:0]       quotient_o,
  output logic signed [sdiv_pkg::Width-1:0]       remainder_o,
  output logic                                    divide_by_zero_o,
  output logic                                    overflowed_o
);

  logic            valid_q;
  sdiv_pkg::word_t quo_d, quo_q, rem_d, rem_q;
  logic            dbz_q, ovf_q;

  always_comb begin
    quo_d = in_data_i.meta.quo_neg ? (~in_data_i.dq + sdiv_pkg::word_t'(1)) : in_data_i.dq;
    rem_d = in_data_i.meta.num_neg ? (~in_data_i.rem + sdiv_pkg::word_t'(1)) : in_data_i.rem;
    if (in_data_i.meta.div_zero) begin
      quo_d = in_data_i.meta.num_neg ? sdiv_pkg::MinNeg : sdiv_pkg::MaxPos;
    end else if (in_data_i.meta.ovf) begin
      quo_d = sdiv_pkg::MaxPos;
      rem_d = '0;
    end
  end

  assign in_ready_o       = !valid_q || out_ready_i;
  assign out_valid_o      = valid_q;
  assign quotient_o       = $signed(quo_q);
  assign remainder_o      = $signed(rem_q);
  assign divide_by_zero_o = dbz_q;
  assign overflowed_o     = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      dbz_q <= in_data_i.meta.div_zero;
      ovf_q <= in_data_i.meta.ovf && !in_data_i.meta.div_zero;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/signed_divider.sv
// Top level of the pipelined signed 32-bit divider.
// Signed divider: quotient truncates toward zero, remainder takes the sign of
// the dividend. A zero divisor gives a saturated quotient (largest positive for
// a non-negative dividend, most negative otherwise), the dividend as remainder
// and divide_by_zero set; the most negative value over minus one gives the
// largest positive quotient, a zero remainder and overflowed set. The datapath
// is a chain of 32 restoring cells, one quotient bit each, between an operand
// stage and a result register: a beat is accepted every cycle while the output
// is not held, and its result passes the operand, cell and result registers
// in that order. Every stage holds under backpressure and bubbles collapse, so
// the input stays ready while empty stages remain.
`default_nettype none

module signed_divider (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [sdiv_pkg::Width-1:0]   dividend_i,
  input  wire logic signed [sdiv_pkg::Width-1:0]   divisor_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [sdiv_pkg::Width-1:0]        quotient_o,
  output logic signed [sdiv_pkg::Width-1:0]        remainder_o,
  output logic                                     divide_by_zero_o,
  output logic                                     overflowed_o
);

  localparam int unsigned NumCells = sdiv_pkg::Width;

  logic             valid_w [NumCells+1];
  logic             ready_w [NumCells+1];
  sdiv_pkg::stage_t data_w  [NumCells+1];

  sdiv_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dividend_i  (dividend_i),
    .divisor_i   (divisor_i),
    .out_valid_o (valid_w[0]),
    .out_ready_i (ready_w[0]),
    .out_data_o  (data_w[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    sdiv_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_w[g]),
      .in_ready_o  (ready_w[g]),
      .in_data_i   (data_w[g]),
      .out_valid_o (valid_w[g+1]),
      .out_ready_i (ready_w[g+1]),
      .out_data_o  (data_w[g+1])
    );
  end

  sdiv_post u_post (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (valid_w[NumCells]),
    .in_ready_o       (ready_w[NumCells]),
    .in_data_i        (data_w[NumCells]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .quotient_o       (quotient_o),
    .remainder_o      (remainder_o),
    .divide_by_zero_o (divide_by_zero_o),
    .overflowed_o     (overflowed_o)
  );

endmodule

`default_nettype wire

FILE: test/signed_divider_tb.sv
// Testbench for signed_divider: corner and random divisions checked against a predictor.
module signed_divider_tb;

  localparam int NumRandom   = 550;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 40;
  localparam int MaxReports  = 10;

  typedef struct packed {
    sdiv_pkg::word_t quotient;
    sdiv_pkg::word_t remainder;
    logic            divide_by_zero;
    logic            overflowed;
  } div_result_t;

  class division_scoreboard;
    div_result_t quotients_due[$];
    int unsigned n_checked;
    int unsigned n_mismatch;
    int unsigned n_by_zero;
    int unsigned n_overflow;
    int unsigned n_ops;

    function div_result_t predict_quotient(sdiv_pkg::word_t num, sdiv_pkg::word_t den);
      div_result_t res;
      sdiv_pkg::word_t mag_num, mag_den, q, r;
      res = '0;
      if (den == '0) begin
        res.quotient = num[sdiv_pkg::Width-1] ? sdiv_pkg::MinNeg : sdiv_pkg::MaxPos;
        res.remainder = num;
        res.divide_by_zero = 1'b1;
      end else if (num == sdiv_pkg::MinNeg && den == sdiv_pkg::AllOne) begin
        res.quotient = sdiv_pkg::MaxPos;
        res.overflowed = 1'b1;
      end else begin
        mag_num = num[sdiv_pkg::Width-1] ? -num : num;
        mag_den = den[sdiv_pkg::Width-1] ? -den : den;
        q = mag_num / mag_den;
        r = mag_num % mag_den;
        res.quotient = (num[sdiv_pkg::Width-1] ^ den[sdiv_pkg::Width-1]) ? -q : q;
        res.remainder = num[sdiv_pkg::Width-1] ? -r : r;
      end
      return res;
    endfunction

    function void note_operands(sdiv_pkg::word_t num, sdiv_pkg::word_t den);
      div_result_t res;
      res = predict_quotient(num, den);
      n_ops++;
      n_by_zero += res.divide_by_zero;
      n_overflow += res.overflowed;
      quotients_due.push_back(res);
    endfunction

    function void check_result(div_result_t got);
      div_result_t want;
      if (quotients_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MaxReports) begin
          $display("unexpected result: q=%h r=%h dbz=%b ovf=%b",
                   got.quotient, got.remainder, got.divide_by_zero, got.overflowed);
        end
        return;
      end
      want = quotients_due.pop_front();
      n_checked++;
      if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
          got.divide_by_zero !== want.divide_by_zero ||
          got.overflowed !== want.overflowed) begin
        n_mismatch++;
        if (n_mismatch <= MaxReports) begin
          $display("mismatch on result %0d: expected q=%h r=%h dbz=%b ovf=%b",
                   n_checked, want.quotient, want.remainder, want.divide_by_zero,
                   want.overflowed);
          $display("                      got      q=%h r=%h dbz=%b ovf=%b",
                   got.quotient, got.remainder, got.divide_by_zero, got.overflowed);
        end
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  sdiv_pkg::word_t dividend_i;
  sdiv_pkg::word_t divisor_i;
  logic            out_valid_o;
  logic            out_ready_i;
  sdiv_pkg::word_t quotient_o;
  sdiv_pkg::word_t remainder_o;
  logic            divide_by_zero_o;
  logic            overflowed_o;

  division_scoreboard sb;
  int idle_pct = 28;

  signed_divider i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .dividend_i      (dividend_i),
    .divisor_i       (divisor_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .quotient_o      (quotient_o),
    .remainder_o     (remainder_o),
    .divide_by_zero_o(divide_by_zero_o),
    .overflowed_o    (overflowed_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic send_division(input sdiv_pkg::word_t num, input sdiv_pkg::word_t den);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    dividend_i <= num;
    divisor_i  <= den;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_operands(num, den);
  endtask

  function automatic sdiv_pkg::word_t random_sign(sdiv_pkg::word_t v);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic sdiv_pkg::word_t pick_corner();
    case ($urandom_range(5))
      0: return sdiv_pkg::MinNeg;
      1: return sdiv_pkg::MaxPos;
      2: return '0;
      3: return sdiv_pkg::word_t'(1);
      4: return sdiv_pkg::AllOne;
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_operands(output sdiv_pkg::word_t num, output sdiv_pkg::word_t den);
    int              kind;
    sdiv_pkg::word_t q;
    sdiv_pkg::word_t d;
    kind = $urandom_range(99);
    if (kind < 25) begin
      num = $urandom;
      den = $urandom;
    end else if (kind < 45) begin
      num = $urandom;
      den = random_sign(sdiv_pkg::word_t'($urandom_range(1, 16)));
    end else if (kind < 60) begin
      d = $urandom >> $urandom_range(8, 30);
      if (d == '0) d = sdiv_pkg::word_t'(1);
      q = $urandom >> $urandom_range(8, 30);
      num = random_sign(q * d);
      den = random_sign(d);
    end else if (kind < 70) begin
      num = $urandom_range(1) ? sdiv_pkg::word_t'($urandom) : pick_corner();
      den = '0;
    end else if (kind < 78) begin
      num = pick_corner();
      den = pick_corner();
    end else if (kind < 88) begin
      den = random_sign($urandom | 32'h4000_0000);
      num = random_sign($urandom >> $urandom_range(2, 31));
    end else begin
      num = random_sign($urandom >> $urandom_range(0, 31));
      den = random_sign($urandom >> $urandom_range(0, 31));
    end
  endtask

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      sb.check_result({quotient_o, remainder_o, divide_by_zero_o, overflowed_o});
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat moved for %0d cycles", QuietLimit);
    $display("** signed_divider: FAILED **");
    $finish;
  end

  initial begin
    sdiv_pkg::word_t num;
    sdiv_pkg::word_t den;
    int              i;
    sb = new;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    dividend_i <= '0;
    divisor_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_division('0, '0);
    send_division(sdiv_pkg::word_t'(5), '0);
    send_division(sdiv_pkg::word_t'(-5), '0);
    send_division(sdiv_pkg::MaxPos, '0);
    send_division(sdiv_pkg::MinNeg, '0);
    send_division(sdiv_pkg::MinNeg, sdiv_pkg::AllOne);
    send_division(sdiv_pkg::MinNeg, sdiv_pkg::word_t'(1));
    send_division(sdiv_pkg::MaxPos, sdiv_pkg::AllOne);
    send_division(sdiv_pkg::MaxPos, sdiv_pkg::MaxPos);
    send_division(sdiv_pkg::MinNeg, sdiv_pkg::MinNeg);
    send_division(sdiv_pkg::MaxPos, sdiv_pkg::MinNeg);
    send_division(sdiv_pkg::MinNeg, sdiv_pkg::MaxPos);
    send_division(sdiv_pkg::word_t'(7), sdiv_pkg::word_t'(2));
    send_division(sdiv_pkg::word_t'(-7), sdiv_pkg::word_t'(2));
    send_division(sdiv_pkg::word_t'(7), sdiv_pkg::word_t'(-2));
    send_division(sdiv_pkg::word_t'(-7), sdiv_pkg::word_t'(-2));
    send_division('0, sdiv_pkg::word_t'(5));
    send_division(sdiv_pkg::word_t'(1), sdiv_pkg::AllOne);
    send_division(sdiv_pkg::AllOne, sdiv_pkg::word_t'(1));
    send_division(sdiv_pkg::AllOne, sdiv_pkg::AllOne);
    send_division(sdiv_pkg::word_t'(6), sdiv_pkg::word_t'(3));
    send_division(sdiv_pkg::word_t'(-6), sdiv_pkg::word_t'(3));
    send_division(sdiv_pkg::word_t'(100), sdiv_pkg::word_t'(1000));
    send_division(sdiv_pkg::MinNeg, sdiv_pkg::word_t'(2));

    for (i = 0; i < NumRandom; i++) begin
      idle_pct = (i >= 200 && i < 350) ? 0 : 28;
      pick_operands(num, den);
      send_division(num, den);
    end
    in_valid_i <= 1'b0;
    idle_pct = 28;

    while (sb.quotients_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("divided %0d operand pairs: %0d by a zero divisor, %0d at overflow",
             sb.n_ops, sb.n_by_zero, sb.n_overflow);
    $display("checked %0d results, %0d mismatches, %0d still outstanding",
             sb.n_checked, sb.n_mismatch, sb.quotients_due.size());
    if (sb.n_mismatch == 0 && sb.quotients_due.size() == 0) begin
      $display("** signed_divider: PASSED **");
    end else begin
      $display("** signed_divider: FAILED **");
    end
    $finish;
  end

endmodule
